>>> sv/irpdt_pkg.sv
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared types and constants for the IR pulse distance transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PhaseW   = 3;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [PhaseW-1:0]   phase_t;

  // request operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t CFG_ADDR_FIRST  = 3'd0;
  localparam cfg_idx_t CFG_ADDR_SECOND = 3'd1;
  localparam cfg_idx_t CFG_LEAD_MARK   = 3'd2;
  localparam cfg_idx_t CFG_LEAD_SPACE  = 3'd3;
  localparam cfg_idx_t CFG_BIT_MARK    = 3'd4;
  localparam cfg_idx_t CFG_ZERO_SPACE  = 3'd5;
  localparam cfg_idx_t CFG_ONE_SPACE   = 3'd6;
  localparam cfg_idx_t CFG_STOP_MARK   = 3'd7;

  // frame phases
  localparam phase_t PH_IDLE       = 3'd0;
  localparam phase_t PH_LEAD_MARK  = 3'd1;
  localparam phase_t PH_LEAD_SPACE = 3'd2;
  localparam phase_t PH_BIT_MARK   = 3'd3;
  localparam phase_t PH_BIT_SPACE  = 3'd4;
  localparam phase_t PH_STOP_MARK  = 3'd5;

  // reset values (NEC timing in carrier half-periods)
  localparam logic [7:0]   ADDR_FIRST_RST  = 8'h00;
  localparam logic [7:0]   ADDR_SECOND_RST = 8'hFF;
  localparam int unsigned  LEAD_MARK_RST   = 750;
  localparam int unsigned  LEAD_SPACE_RST  = 375;
  localparam int unsigned  BIT_MARK_RST    = 47;
  localparam int unsigned  ZERO_SPACE_RST  = 47;
  localparam int unsigned  ONE_SPACE_RST   = 141;
  localparam int unsigned  STOP_MARK_RST   = 47;

endpackage

>>> sv/irpdt_if.sv
// ----------------------------------------------------------------------------
// irpdt interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface irpdt_req_if ();
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface irpdt_rsp_if ();
  logic valid;
  logic ready;
  logic ir_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output ir_level, output busy_res, output frame_done,
                  input ready);
  modport sink   (input valid, input ir_level, input busy_res, input frame_done,
                  output ready);
endinterface

interface irpdt_cfg_if import irpdt_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/ir_pulse_distance_transmitter_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_core
// NEC-style IR frame transmitter: leader, 32 LSB-first data bits, stop mark.
// ----------------------------------------------------------------------------
// channel | dir | payload                          | transaction
// req_i   | in  | op, key                          | one tick or send request
// rsp_o   | out | ir_level, busy_res, frame_done   | one result per request
// cfg_i   | in  | index, data                      | one register write
//
// For each transaction, state update and result are computed combinationally
// between the state registers and a two-entry output buffer.
// A new transaction is taken every cycle while the skid slot is empty.
// The result appears on rsp_o the cycle after acceptance unless rsp_o stalls.
// Reset loads the NEC timing defaults; cfg_i is always ready.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_core import irpdt_pkg::*; #(
  parameter int unsigned FRAME_BITS     = 32,
  parameter int unsigned DURATION_WIDTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  irpdt_req_if.sink   req_i,
  irpdt_rsp_if.source rsp_o,
  irpdt_cfg_if.sink   cfg_i
);

  localparam int unsigned DW     = DURATION_WIDTH;
  localparam int unsigned BidxW  = $clog2(FRAME_BITS);

  typedef logic [DW-1:0] dur_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
  } rsp_t;

  // configuration registers
  logic [7:0] addr_first_q, addr_second_q;
  dur_t       lead_mark_q, lead_space_q, bit_mark_q;
  dur_t       zero_space_q, one_space_q, stop_mark_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_first_q  <= ADDR_FIRST_RST;
      addr_second_q <= ADDR_SECOND_RST;
      lead_mark_q   <= DW'(LEAD_MARK_RST);
      lead_space_q  <= DW'(LEAD_SPACE_RST);
      bit_mark_q    <= DW'(BIT_MARK_RST);
      zero_space_q  <= DW'(ZERO_SPACE_RST);
      one_space_q   <= DW'(ONE_SPACE_RST);
      stop_mark_q   <= DW'(STOP_MARK_RST);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ADDR_FIRST:  addr_first_q  <= cfg_i.data[7:0];
        CFG_ADDR_SECOND: addr_second_q <= cfg_i.data[7:0];
        CFG_LEAD_MARK:   lead_mark_q   <= cfg_i.data[DW-1:0];
        CFG_LEAD_SPACE:  lead_space_q  <= cfg_i.data[DW-1:0];
        CFG_BIT_MARK:    bit_mark_q    <= cfg_i.data[DW-1:0];
        CFG_ZERO_SPACE:  zero_space_q  <= cfg_i.data[DW-1:0];
        CFG_ONE_SPACE:   one_space_q   <= cfg_i.data[DW-1:0];
        CFG_STOP_MARK:   stop_mark_q   <= cfg_i.data[DW-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  phase_t                phase_q, phase_d;
  dur_t                  dur_q, dur_d;
  logic [BidxW-1:0]      bidx_q, bidx_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic                  carrier_q, carrier_d;

  logic       req_acc;
  logic       in_mark;
  logic       last;
  rsp_t       res;

  assign in_mark    = (phase_q == PH_LEAD_MARK) || (phase_q == PH_BIT_MARK) ||
                      (phase_q == PH_STOP_MARK);
  assign last       = dur_q <= DW'(1);

  always_comb begin
    phase_d        = phase_q;
    dur_d          = dur_q;
    bidx_d         = bidx_q;
    shift_d        = shift_q;
    carrier_d      = carrier_q;
    res.ir_level   = 1'b0;
    res.frame_done = 1'b0;
    if (req_i.op == OP_SEND) begin
      if (phase_q == PH_IDLE) begin
        shift_d   = FRAME_BITS'({~req_i.key, req_i.key, addr_second_q, addr_first_q});
        bidx_d    = '0;
        carrier_d = 1'b0;
        phase_d   = PH_LEAD_MARK;
        dur_d     = lead_mark_q;
      end
      res.ir_level = carrier_d;
    end else if (phase_q != PH_IDLE) begin
      carrier_d    = in_mark ? ~carrier_q : 1'b0;
      res.ir_level = carrier_d;
      if (!last) begin
        dur_d = dur_q - DW'(1);
      end else begin
        case (phase_q)
          PH_LEAD_MARK: begin
            phase_d = PH_LEAD_SPACE;
            dur_d   = lead_space_q;
          end
          PH_LEAD_SPACE: begin
            phase_d = PH_BIT_MARK;
            dur_d   = bit_mark_q;
          end
          PH_BIT_MARK: begin
            phase_d = PH_BIT_SPACE;
            dur_d   = shift_q[0] ? one_space_q : zero_space_q;
          end
          PH_BIT_SPACE: begin
            shift_d = shift_q >> 1;
            if (bidx_q == BidxW'(FRAME_BITS - 1)) begin
              bidx_d  = '0;
              phase_d = PH_STOP_MARK;
              dur_d   = stop_mark_q;
            end else begin
              bidx_d  = bidx_q + BidxW'(1);
              phase_d = PH_BIT_MARK;
              dur_d   = bit_mark_q;
            end
          end
          default: begin
            phase_d        = PH_IDLE;
            dur_d          = '0;
            bidx_d         = '0;
            shift_d        = '0;
            carrier_d      = 1'b0;
            res.frame_done = 1'b1;
          end
        endcase
      end
    end
    res.busy_res = phase_d != PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      dur_q     <= '0;
      bidx_q    <= '0;
      shift_q   <= '0;
      carrier_q <= 1'b0;
    end else if (req_acc) begin
      phase_q   <= phase_d;
      dur_q     <= dur_d;
      bidx_q    <= bidx_d;
      shift_q   <= shift_d;
      carrier_q <= carrier_d;
    end
  end

  // output register plus skid slot
  logic out_valid_q, skd_valid_q;
  rsp_t out_q, skd_q;
  logic pop, head_free;

  assign req_i.ready = !skd_valid_q;
  assign req_acc     = req_i.valid && req_i.ready;
  assign pop         = out_valid_q && rsp_o.ready;
  assign head_free   = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skd_valid_q <= 1'b0;
    end else if (head_free) begin
      if (skd_valid_q) begin
        out_valid_q <= 1'b1;
        skd_valid_q <= req_acc;
      end else begin
        out_valid_q <= req_acc;
      end
    end else if (req_acc) begin
      skd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_free) begin
      if (skd_valid_q) begin
        out_q <= skd_q;
        if (req_acc) skd_q <= res;
      end else begin
        if (req_acc) out_q <= res;
      end
    end else if (req_acc) begin
      skd_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ir_level   = out_q.ir_level;
  assign rsp_o.busy_res   = out_q.busy_res;
  assign rsp_o.frame_done = out_q.frame_done;

  // checks
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_done |-> !out_q.busy_res)
    else $error("frame_done reported while still busy");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> (!carrier_q && bidx_q == '0 && shift_q == '0))
    else $error("idle with stale frame state");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skd_valid_q |-> out_valid_q)
    else $error("skid slot filled while head empty");

  a_space_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !req_i.op && (phase_q == PH_LEAD_SPACE || phase_q == PH_BIT_SPACE)
    |=> !carrier_q)
    else $error("carrier high after space tick");

endmodule
